// File: design/dnle_pkg.sv
// dnle_pkg: shared types and constants for the dns name label encoder
// depends on nothing; used by the top level, its checker and the testbench
package dnle_pkg;

    // label buffer capacity and the widths that follow from it
    localparam int LABEL_DEPTH = 32;
    localparam int IDX_W       = $clog2(LABEL_DEPTH);
    localparam int CNT_W       = $clog2(LABEL_DEPTH + 1);

    // label separator and name terminator
    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] TERM_BYTE = 8'h00;

    // one input item: a character of the dotted name
    typedef struct packed {
        logic [7:0] ch;
        logic       final_char;
    } in_item_t;

    // one result item: a byte of the wire form
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_length;
        logic       truncated;
        logic       end_of_name;
    } out_item_t;

endpackage

// File: design/dns_name_label_encoder.sv
// dns_name_label_encoder: dotted host name to dns wire form, one byte per cycle while the output is not stalled
// depends on dnle_pkg; label characters held in a one-port-read synchronous memory

// A character other than '.' is taken and written to the label memory; it
// produces no result. A '.' leaves as a length byte and the n held characters,
// one output byte per cycle while the output is not stalled, and the last
// character of a name adds a flush of its label plus the zero terminator
// (a final '.' flushes its label and then an empty one). The single read
// port of the label memory yields one character per cycle; input is held
// off while a flush is in progress.
// Characters past LABEL_DEPTH are dropped and the length byte is marked
// truncated. Results sit in an output register, so backpressure only stalls.
module dns_name_label_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dnle_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dnle_pkg::out_item_t out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;
    localparam logic [1:0] S_TERM = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [dnle_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic [dnle_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       fin_reg, fin_next;
    logic                       dot_reg, dot_next;
    logic                       out_valid_reg, out_valid_next;
    dnle_pkg::out_item_t        out_reg, out_next;

    logic [7:0]                 mem [dnle_pkg::LABEL_DEPTH];
    logic [7:0]                 rdata_reg;
    logic                       wr_en;
    logic [dnle_pkg::IDX_W-1:0] wr_addr;

    logic accept;
    logic can_load;
    logic flush_done;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign wr_addr   = count_reg[dnle_pkg::IDX_W-1:0];

    // label memory: write in idle, read every cycle at the next index;
    // the length cycle always precedes the data cycles, so a character
    // written just before a flush is read back after its write lands
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_data.ch;
        end
        rdata_reg <= mem[idx_next];
    end

    // sequencer and output register next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        fin_next       = fin_reg;
        dot_next       = dot_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        wr_en          = 1'b0;
        flush_done     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    fin_next = in_data.final_char;
                    if (in_data.ch == dnle_pkg::DOT_CHAR)
                    begin
                        dot_next   = 1'b1;
                        state_next = S_LEN;
                    end
                    else
                    begin
                        dot_next = 1'b0;
                        if (count_reg < dnle_pkg::CNT_W'(dnle_pkg::LABEL_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (in_data.final_char)
                        begin
                            state_next = S_LEN;
                        end
                    end
                end
            end
            S_LEN:
            begin
                if (can_load)
                begin
                    out_next.out_byte    = 8'(count_reg);
                    out_next.is_length   = 1'b1;
                    out_next.truncated   = ovf_reg;
                    out_next.end_of_name = 1'b0;
                    out_valid_next       = 1'b1;
                    if (count_reg == '0)
                    begin
                        flush_done = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DATA;
                    end
                end
            end
            S_DATA:
            begin
                if (can_load)
                begin
                    out_next.out_byte    = rdata_reg;
                    out_next.is_length   = 1'b0;
                    out_next.truncated   = 1'b0;
                    out_next.end_of_name = 1'b0;
                    out_valid_next       = 1'b1;
                    if (dnle_pkg::CNT_W'(idx_reg) == count_reg - 1'b1)
                    begin
                        flush_done = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_TERM:
            begin
                if (can_load)
                begin
                    out_next.out_byte    = dnle_pkg::TERM_BYTE;
                    out_next.is_length   = 1'b0;
                    out_next.truncated   = 1'b0;
                    out_next.end_of_name = 1'b1;
                    out_valid_next       = 1'b1;
                    fin_next             = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of a flush: clear the label, then flush again, terminate or idle
        if (flush_done)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            idx_next   = '0;
            if (fin_reg && dot_reg)
            begin
                dot_next   = 1'b0;
                state_next = S_LEN;
            end
            else if (fin_reg)
            begin
                state_next = S_TERM;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            fin_reg       <= 1'b0;
            dot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            fin_reg       <= fin_next;
            dot_reg       <= dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: design/dnle_checker.sv
// dnle_checker: port-level assertions for dns_name_label_encoder
// depends on dnle_pkg; attached to the top level by the bind below
module dnle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input dnle_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input dnle_pkg::out_item_t out_data
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // the terminator is a plain zero byte
    a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_name |->
            out_data.out_byte == 8'h00 && !out_data.is_length && !out_data.truncated)
        else $error("malformed terminator");

    // a length byte never exceeds the buffer capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_length |->
            out_data.out_byte <= 8'(dnle_pkg::LABEL_DEPTH))
        else $error("length byte beyond capacity");

    // a truncated label reports a full buffer
    a_trunc_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_length && out_data.truncated |->
            out_data.out_byte == 8'(dnle_pkg::LABEL_DEPTH))
        else $error("truncated label with short length");

    // a dot or a last character starts a flush, so input is held off next cycle
    a_no_in_mid: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
            (in_data.ch == dnle_pkg::DOT_CHAR || in_data.final_char) |=> !in_ready)
        else $error("input item taken while a flush is due");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: verif/tb_dns_name_label_encoder.sv
// tb_dns_name_label_encoder: self-checking testbench for the dns name label encoder
// depends on dnle_pkg and design/dns_name_label_encoder.sv; predicts the wire form
// of each character item and compares every result item against it in order

module tb_dns_name_label_encoder;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    // longest flush: a full label plus two length bytes and the terminator
    localparam int SETTLE_CYCLES = 2 * dnle_pkg::LABEL_DEPTH + 16;
    localparam int RANDOM_ITEMS  = 350;
    localparam int MAX_PRINTED   = 30;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    dnle_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    dnle_pkg::out_item_t out_data;

    // predictor state: characters of the label being collected
    logic [7:0] label_chars [dnle_pkg::LABEL_DEPTH];
    int         label_len     = 0;
    logic       label_dropped = 1'b0;

    dnle_pkg::out_item_t wire_bytes_due[$];
    logic [7:0]          name_chars[$];

    int send_idle_pct  = 23;
    int recv_stall_pct = 52;
    int items_sent     = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    dns_name_label_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls at random
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // label length byte then the held characters
    task automatic emit_label();
        dnle_pkg::out_item_t r;
        r.out_byte    = 8'(label_len);
        r.is_length   = 1'b1;
        r.truncated   = label_dropped;
        r.end_of_name = 1'b0;
        wire_bytes_due.push_back(r);
        for (int k = 0; k < label_len; k++)
        begin
            r.out_byte  = label_chars[k];
            r.is_length = 1'b0;
            r.truncated = 1'b0;
            wire_bytes_due.push_back(r);
        end
        label_len     = 0;
        label_dropped = 1'b0;
    endtask

    // wire form caused by one accepted character
    task automatic encode_char(input dnle_pkg::in_item_t it);
        dnle_pkg::out_item_t term;
        if (it.ch == dnle_pkg::DOT_CHAR)
            emit_label();
        else if (label_len < dnle_pkg::LABEL_DEPTH)
        begin
            label_chars[label_len] = it.ch;
            label_len++;
        end
        else
            label_dropped = 1'b1;
        // implied final dot, then the terminator
        if (it.final_char)
        begin
            emit_label();
            term.out_byte    = dnle_pkg::TERM_BYTE;
            term.is_length   = 1'b0;
            term.truncated   = 1'b0;
            term.end_of_name = 1'b1;
            wire_bytes_due.push_back(term);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        dnle_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (wire_bytes_due.size() == 0)
                report_mismatch($sformatf("unexpected item byte %02h", out_data.out_byte));
            else
            begin
                want = wire_bytes_due.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                              out_data.out_byte, want.out_byte));
                if (out_data.is_length !== want.is_length)
                    report_mismatch($sformatf("is_length %b, wanted %b",
                                              out_data.is_length, want.is_length));
                if (out_data.truncated !== want.truncated)
                    report_mismatch($sformatf("truncated %b, wanted %b",
                                              out_data.truncated, want.truncated));
                if (out_data.end_of_name !== want.end_of_name)
                    report_mismatch($sformatf("end_of_name %b, wanted %b",
                                              out_data.end_of_name, want.end_of_name));
            end
        end
    end

    // one character item, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        dnle_pkg::in_item_t it;
        it.ch         = c;
        it.final_char = last;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        encode_char(it);
        items_sent++;
    endtask

    task automatic send_queued_name();
        foreach (name_chars[i])
            send_char(name_chars[i], i == name_chars.size() - 1);
        name_chars.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            name_chars.push_back(s[i]);
        send_queued_name();
    endtask

    function automatic logic [7:0] rand_label_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == dnle_pkg::DOT_CHAR);
        return c;
    endfunction

    // sender holds off until every pending result has left, then settles
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (wire_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_basic_names();
        send_text("ab.cd");
        send_text("q");
    endtask

    // leading dot and consecutive dots give zero length bytes
    task automatic test_empty_labels();
        send_text(".a..b");
    endtask

    // final dot flushes its label, then an empty one
    task automatic test_trailing_dot();
        send_text("x.");
        send_text(".");
    endtask

    // zero character and the top of the byte range are ordinary characters
    task automatic test_char_extremes();
        name_chars.push_back(8'h00);
        name_chars.push_back(8'hFF);
        name_chars.push_back(8'h2D);
        name_chars.push_back(8'h2F);
        name_chars.push_back(8'h80);
        send_queued_name();
    endtask

    // one character past capacity, dropped on the final item
    task automatic test_long_label();
        for (int i = 0; i <= dnle_pkg::LABEL_DEPTH; i++)
            name_chars.push_back(rand_label_char());
        send_queued_name();
    endtask

    // mostly well-formed names with random content, some noise
    task automatic send_random_name();
        int n_labels;
        int len;
        name_chars.delete();
        if ($urandom_range(7) == 0)
        begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
                name_chars.push_back(($urandom_range(3) == 0) ?
                                     dnle_pkg::DOT_CHAR : 8'($urandom_range(255)));
        end
        else
        begin
            n_labels = $urandom_range(1, 4);
            for (int i = 0; i < n_labels; i++)
            begin
                if (i != 0)
                    name_chars.push_back(dnle_pkg::DOT_CHAR);
                len = ($urandom_range(11) == 0) ?
                      $urandom_range(dnle_pkg::LABEL_DEPTH - 4, dnle_pkg::LABEL_DEPTH + 8)
                    : $urandom_range(0, 6);
                for (int j = 0; j < len; j++)
                    name_chars.push_back(rand_label_char());
            end
            if ($urandom_range(4) == 0)
                name_chars.push_back(dnle_pkg::DOT_CHAR);
            if (name_chars.size() == 0)
                name_chars.push_back(rand_label_char());
        end
        send_queued_name();
    endtask

    task automatic test_random_names(input int idle_pct, input int stall_pct,
                                     input int item_target);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < item_target)
            send_random_name();
    endtask

    initial
    begin
        int base;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_names();
        test_empty_labels();
        test_trailing_dot();
        test_char_extremes();
        test_long_label();
        wait_for_results();

        base = items_sent;
        test_random_names(23, 52, base + RANDOM_ITEMS / 3);
        wait_for_results();
        test_random_names(52, 23, base + 2 * RANDOM_ITEMS / 3);
        test_random_names(0, 0, base + RANDOM_ITEMS);
        wait_for_results();

        if (wire_bytes_due.size() != 0)
            report_mismatch($sformatf("%0d items never arrived", wire_bytes_due.size()));
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
